>>> hdl/vsfs_pkg.sv
// Shared types, constants and frame-building functions for the VFD segment frame shifter.
`default_nettype none
package vsfs_pkg;

    localparam int NUM_POS       = 4;
    localparam int FRAME_BITS    = 40;
    localparam int NUM_GLYPHS    = 13;
    localparam int SEGS          = 7;
    localparam int DOT_LSB       = 8;
    localparam int ALWAYS_ON_BIT = 37;
    localparam int CNT_W         = $clog2(FRAME_BITS);
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [6:0] SHAPE_VALID   = 7'h62;
    localparam logic [6:0] SHAPE_INVALID = 7'h02;
    localparam logic [7:0] DOT_MASK_RST  = 8'd24;

    localparam logic [1:0] IND_OFF     = 2'd0;
    localparam logic [1:0] IND_VALID   = 2'd1;
    localparam logic [1:0] IND_INVALID = 2'd2;

    typedef enum logic [1:0] {
        MODE_CHAR = 2'd0,
        MODE_DOTS = 2'd1,
        MODE_IND  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef logic [3:0]              t_glyph;
    typedef logic [NUM_POS-1:0][3:0] t_glyphs;
    typedef logic [CNT_W-1:0]        t_bitidx;

    typedef struct packed {
        t_mode      kind;
        logic [1:0] pos;
        t_glyph     glyph;
        logic [7:0] dots;
        logic [1:0] ind;
        logic       emit;
    } t_cmd;

    localparam logic [6:0] GLYPH_SHAPE [NUM_GLYPHS] = '{
        7'h00, 7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D,
        7'h7D, 7'h07, 7'h7F, 7'h67, 7'h40, 7'h08
    };

    // frame bit (segment number minus one) per position, segments a..g
    localparam t_bitidx SEG_BIT [NUM_POS][SEGS] = '{
        '{6'd8,  6'd6,  6'd7,  6'd8,  6'd8,  6'd10, 6'd9},
        '{6'd0,  6'd1,  6'd3,  6'd2,  6'd36, 6'd5,  6'd4},
        '{6'd35, 6'd34, 6'd32, 6'd35, 6'd33, 6'd38, 6'd39},
        '{6'd29, 6'd28, 6'd26, 6'd25, 6'd27, 6'd31, 6'd30}
    };

    function automatic t_glyph glyph_of(input logic [7:0] code);
        t_glyph g;
        unique case (code)
            8'h30:   g = 4'd1;
            8'h31:   g = 4'd2;
            8'h32:   g = 4'd3;
            8'h33:   g = 4'd4;
            8'h34:   g = 4'd5;
            8'h35:   g = 4'd6;
            8'h36:   g = 4'd7;
            8'h37:   g = 4'd8;
            8'h38:   g = 4'd9;
            8'h39:   g = 4'd10;
            8'h2D:   g = 4'd11;
            8'h5F:   g = 4'd12;
            default: g = 4'd0;
        endcase
        return g;
    endfunction

    function automatic logic [FRAME_BITS-1:0] build_frame(
        input t_glyphs    g,
        input logic [7:0] dots,
        input logic [1:0] ind
    );
        logic [FRAME_BITS-1:0] f;
        logic [6:0]            shape;
        f = '0;
        f[DOT_LSB +: 8] = dots;
        f[ALWAYS_ON_BIT] = 1'b1;
        for (int p = 0; p < NUM_POS; p++) begin
            shape = (g[p] < 4'(NUM_GLYPHS)) ? GLYPH_SHAPE[g[p]] : 7'h00;
            if (p == 0) begin
                if (ind == IND_VALID) begin
                    shape = SHAPE_VALID;
                end else if (ind == IND_INVALID) begin
                    shape = SHAPE_INVALID;
                end
            end
            for (int s = 0; s < SEGS; s++) begin
                if (shape[s]) begin
                    f[SEG_BIT[p][s]] = 1'b1;
                end
            end
        end
        return f;
    endfunction

endpackage
`default_nettype wire

>>> hdl/vfd_segment_frame_shifter.sv
// Top level: VFD segment frame shifter, front end, command queue and shift back end.
// A command is registered in the queue before the back end sees it; when the back end
// takes a reloading command it loads the frame register, which offers the first bit.
// The frame then leaves the one-bit-per-clock shift register while the output is ready,
// and no further command is taken until its last bit is accepted.
// Reset: synchronous active low; clears glyphs, dots, indicator, queue, sets mask to 24.
`default_nettype none
module vfd_segment_frame_shifter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_mode,
    input  wire logic [1:0] i_position,
    input  wire logic [7:0] i_char_code,
    input  wire logic [7:0] i_dot_bits,
    input  wire logic [1:0] i_indicator,
    input  wire logic       i_reload,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_serial_bit,
    output logic            o_strobe_last
);
    import vsfs_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    vsfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_char_code (i_char_code),
        .i_dot_bits  (i_dot_bits),
        .i_indicator (i_indicator),
        .i_reload    (i_reload),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (f_cmd)
    );

    vsfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    vsfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_serial_bit  (o_serial_bit),
        .o_strobe_last (o_strobe_last)
    );

endmodule
`default_nettype wire

>>> hdl/vsfs_front.sv
// Command front end: accepts items, decodes mode and character, drops unused modes.
`default_nettype none
module vsfs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_mode,
    input  wire logic [1:0]    i_position,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [7:0]    i_dot_bits,
    input  wire logic [1:0]    i_indicator,
    input  wire logic          i_reload,
    input  wire logic          i_q_full,
    output logic               o_push,
    output vsfs_pkg::t_cmd     o_cmd
);
    import vsfs_pkg::*;

    t_mode w_mode;

    assign w_mode     = t_mode'(i_mode);
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && (w_mode != MODE_NONE);

    always_comb begin
        o_cmd.kind  = w_mode;
        o_cmd.pos   = i_position;
        o_cmd.glyph = glyph_of(i_char_code);
        o_cmd.dots  = i_dot_bits;
        o_cmd.ind   = i_indicator;
        o_cmd.emit  = (w_mode == MODE_IND) ? 1'b1 : i_reload;
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push) else $error("push into full queue");
    a_mode_none_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mode == MODE_NONE) |-> !o_push) else $error("unused mode queued");
    a_ind_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && w_mode == MODE_IND) |-> o_cmd.emit) else $error("indicator without reload");

endmodule
`default_nettype wire

>>> hdl/vsfs_queue.sv
// Two-entry command queue between front end and frame back end.
`default_nettype none
module vsfs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vsfs_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output vsfs_pkg::t_cmd      o_cmd
);
    import vsfs_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH)) else $error("queue count overflow");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push while full");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule
`default_nettype wire

>>> hdl/vsfs_back.sv
// Back end: display state, frame build and serial shift with strobe on the last bit.
`default_nettype none
module vsfs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_data,
    input  wire logic           i_q_valid,
    input  wire vsfs_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_serial_bit,
    output logic                o_strobe_last
);
    import vsfs_pkg::*;

    logic [7:0]            r_dot_mask;
    t_glyphs               r_glyph, n_glyph;
    logic [7:0]            r_dot, n_dot;
    logic [1:0]            r_ind, n_ind;
    logic [FRAME_BITS-1:0] r_frame;
    logic [FRAME_BITS-1:0] w_frame;
    t_bitidx               r_cnt;
    logic                  r_busy;
    logic                  w_emit;
    logic                  w_out_acc;
    logic                  w_last;

    assign o_pop         = i_q_valid && !r_busy;
    assign o_out_valid   = r_busy;
    assign w_last        = (r_cnt == t_bitidx'(FRAME_BITS - 1));
    assign o_serial_bit  = r_frame[FRAME_BITS-1];
    assign o_strobe_last = w_last;
    assign w_out_acc     = r_busy && i_out_ready;

    always_comb begin
        n_glyph = r_glyph;
        n_dot   = r_dot;
        n_ind   = r_ind;
        w_emit  = 1'b0;
        if (o_pop) begin
            w_emit = i_cmd.emit;
            unique case (i_cmd.kind)
                MODE_CHAR: n_glyph[i_cmd.pos] = i_cmd.glyph;
                MODE_DOTS: n_dot = i_cmd.dots;
                MODE_IND:  n_ind = i_cmd.ind;
                default:   w_emit = 1'b0;
            endcase
            if (w_emit) begin
                n_dot = n_dot & r_dot_mask;
            end
        end
        w_frame = build_frame(n_glyph, n_dot, n_ind);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_mask <= DOT_MASK_RST;
            r_glyph    <= '0;
            r_dot      <= '0;
            r_ind      <= IND_OFF;
            r_busy     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dot_mask <= i_cfg_data;
            end
            r_glyph <= n_glyph;
            r_dot   <= n_dot;
            r_ind   <= n_ind;
            if (w_emit) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_frame <= w_frame;
        end else if (w_out_acc) begin
            r_frame <= {r_frame[FRAME_BITS-2:0], 1'b0};
        end
    end

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last) |=> !r_busy) else $error("shift runs past last bit");
    a_emit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_busy && r_cnt == '0)) else $error("frame load did not start shift");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_out_ready) |=> ($stable(r_frame) && $stable(r_cnt)))
        else $error("frame moved while stalled");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_out_acc) |=> !$past(o_pop)) else $error("command taken mid-frame");

endmodule
`default_nettype wire
